// ===== rtl/console_line_editor_assert.svh =====
// Assertion macros for the line editor RTL.
// Simulation builds expand them; synthesis builds see empty bodies.
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CLE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CLE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CLE_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define CLE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/cle_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the line editor.
// No dependencies.
`default_nettype none
package cle_pkg;

   localparam int LINE_LEN   = 256;
   localparam int IDX_W      = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int POS_W      = $clog2(LINE_LEN + 1);
   localparam int KIND_W     = 2;
   localparam int KEY_W      = 8;
   localparam int OFFSET_W   = 10;
   localparam int RIDX_W     = 8;
   localparam int OUT_POS_W  = 9;
   localparam int CHAR_W     = 8;
   localparam int MOVE_W     = ((POS_W > OFFSET_W) ? POS_W : OFFSET_W) + 2;
   localparam int CMP_W      = (POS_W > RIDX_W) ? POS_W : RIDX_W;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_PAD_W  = REQ_DATA_W - (KEY_W + OFFSET_W + RIDX_W);
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 + 2 * OUT_POS_W + CHAR_W);

   typedef enum logic [KIND_W-1:0] {
      KIND_KEY  = 2'd0,
      KIND_MOVE = 2'd1,
      KIND_READ = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   localparam logic [KEY_W-1:0] KEY_HOME      = 8'd1;
   localparam logic [KEY_W-1:0] KEY_END       = 8'd5;
   localparam logic [KEY_W-1:0] KEY_KILL      = 8'd11;
   localparam logic [KEY_W-1:0] KEY_TRANSPOSE = 8'd20;
   localparam logic [KEY_W-1:0] KEY_WORD_DEL  = 8'd23;
   localparam logic [KEY_W-1:0] KEY_DEL       = 8'd127;
   localparam logic [KEY_W-1:0] KEY_PRINT_LO  = 8'd32;
   localparam logic [KEY_W-1:0] KEY_PRINT_HI  = 8'd126;
   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_HOME,
      CMD_END,
      CMD_KILL,
      CMD_MOVE,
      CMD_RD_IDX,
      CMD_INS_INIT,
      CMD_SHR_ISSUE,
      CMD_SHR_STEP,
      CMD_PUT,
      CMD_DEL_INIT,
      CMD_SCAN_INIT,
      CMD_SCAN_STEP,
      CMD_SCAN_SPACE,
      CMD_SCAN_ZERO,
      CMD_SHL_ISSUE,
      CMD_SHL_STEP,
      CMD_SHL_FIN,
      CMD_TR_INIT,
      CMD_TR_RD_HI,
      CMD_TR_RD_LO,
      CMD_TR_WR_HI,
      CMD_TR_WR_LO,
      CMD_RESULT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       accepted;
      logic       dropped;
      logic       with_read;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic cursor_zero;
      logic cursor_one;
      logic short_line;
      logic ptr_at_cursor;
      logic ptr_next_at_cursor;
      logic ptr_zero;
      logic src_at_end;
      logic space_hit;
   } status_type;

   function automatic logic [OUT_POS_W-1:0] out_pos(input logic [POS_W-1:0] pos);
      logic [POS_W+OUT_POS_W-1:0] wide;
      wide = {{OUT_POS_W{1'b0}}, pos};
      return wide[OUT_POS_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cle_dpath.sv =====
// Line editor datapath: line memory, cursor and length, shift pointers, result register.
// Depends on cle_pkg and console_line_editor_assert.svh; driven by cle_ctrl commands.
`default_nettype none
`include "console_line_editor_assert.svh"
module cle_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cle_pkg::cmd_type                    cmd,
   input  wire logic [cle_pkg::KEY_W-1:0]           key_code,
   input  wire logic signed [cle_pkg::OFFSET_W-1:0] move_offset,
   input  wire logic [cle_pkg::RIDX_W-1:0]          read_index,
   output cle_pkg::status_type                      status,
   output logic                                     res_accepted,
   output logic                                     res_dropped,
   output logic [cle_pkg::OUT_POS_W-1:0]            res_cursor,
   output logic [cle_pkg::OUT_POS_W-1:0]            res_length,
   output logic [cle_pkg::CHAR_W-1:0]               res_char
);
   import cle_pkg::*;

   logic [CHAR_W-1:0] line_mem [LINE_LEN];

   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] length_ff, length_in;
   logic [POS_W-1:0] ptr_ff, ptr_in;
   logic [POS_W-1:0] src_ff, src_in;
   logic [POS_W-1:0] dst_ff, dst_in;
   logic [KEY_W-1:0] key_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic [RIDX_W-1:0] index_ff;
   logic [CHAR_W-1:0] rd_data_ff;
   logic [CHAR_W-1:0] hold_ff, hold_in;

   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [CHAR_W-1:0] wr_data;

   logic [POS_W-1:0] ptr_dec;
   logic [POS_W-1:0] ptr_dec2;
   logic [POS_W-1:0] ptr_inc;
   logic [POS_W-1:0] cursor_dec;
   logic [POS_W-1:0] cursor_dec2;
   logic [POS_W-1:0] cursor_inc;
   logic [POS_W-1:0] trans_pos;
   logic signed [MOVE_W-1:0] move_sum;
   logic signed [MOVE_W-1:0] move_len;
   logic [POS_W-1:0] move_pos;
   logic [RIDX_W+IDX_W-1:0] index_wide;
   logic [IDX_W-1:0] index_addr;
   logic index_in_line;

   assign ptr_dec     = ptr_ff - 1'b1;
   assign ptr_dec2    = ptr_ff - POS_W'(2);
   assign ptr_inc     = ptr_ff + 1'b1;
   assign cursor_dec  = cursor_ff - 1'b1;
   assign cursor_dec2 = cursor_ff - POS_W'(2);
   assign cursor_inc  = cursor_ff + 1'b1;
   assign trans_pos   = (cursor_ff >= length_ff) ? (length_ff - 1'b1) : cursor_ff;

   assign move_len = $signed(MOVE_W'(length_ff));
   assign move_sum = MOVE_W'(offset_ff) + $signed(MOVE_W'(cursor_ff));

   always_comb begin
      if (move_sum < 0) begin
         move_pos = '0;
      end else if (move_sum > move_len) begin
         move_pos = length_ff;
      end else begin
         move_pos = move_sum[POS_W-1:0];
      end
   end

   assign index_wide    = {{IDX_W{1'b0}}, index_ff};
   assign index_addr    = index_wide[IDX_W-1:0];
   assign index_in_line = CMP_W'(index_ff) < CMP_W'(length_ff);

   always_comb begin
      status.full               = (length_ff == POS_W'(LINE_LEN));
      status.cursor_zero        = (cursor_ff == '0);
      status.cursor_one         = (cursor_ff == POS_W'(1));
      status.short_line         = (length_ff < POS_W'(2));
      status.ptr_at_cursor      = (ptr_ff == cursor_ff);
      status.ptr_next_at_cursor = (ptr_ff == cursor_inc);
      status.ptr_zero           = (ptr_ff == '0);
      status.src_at_end         = (src_ff == length_ff);
      status.space_hit          = (rd_data_ff == SPACE_CHAR);
   end

   always_comb begin
      cursor_in = cursor_ff;
      length_in = length_ff;
      ptr_in    = ptr_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      hold_in   = hold_ff;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[IDX_W-1:0];
      wr_data   = rd_data_ff;
      case (cmd.op)
         CMD_HOME: begin
            cursor_in = '0;
         end
         CMD_END: begin
            cursor_in = length_ff;
         end
         CMD_KILL: begin
            length_in = cursor_ff;
         end
         CMD_MOVE: begin
            cursor_in = move_pos;
         end
         CMD_RD_IDX: begin
            rd_en   = 1'b1;
            rd_addr = index_addr;
         end
         CMD_INS_INIT: begin
            ptr_in = length_ff;
         end
         CMD_SHR_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IDX_W-1:0];
         end
         CMD_SHR_STEP: begin
            wr_en   = 1'b1;
            ptr_in  = ptr_dec;
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[IDX_W-1:0];
         end
         CMD_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = cursor_ff[IDX_W-1:0];
            wr_data   = key_ff;
            cursor_in = cursor_inc;
            length_in = length_ff + 1'b1;
         end
         CMD_DEL_INIT: begin
            dst_in    = cursor_dec;
            src_in    = cursor_ff;
            cursor_in = cursor_dec;
         end
         CMD_SCAN_INIT: begin
            ptr_in  = cursor_dec2;
            src_in  = cursor_ff;
            rd_en   = 1'b1;
            rd_addr = cursor_dec2[IDX_W-1:0];
         end
         CMD_SCAN_STEP: begin
            ptr_in  = ptr_dec;
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IDX_W-1:0];
         end
         CMD_SCAN_SPACE: begin
            dst_in    = ptr_inc;
            cursor_in = ptr_inc;
         end
         CMD_SCAN_ZERO: begin
            dst_in    = '0;
            cursor_in = '0;
         end
         CMD_SHL_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = src_ff[IDX_W-1:0];
            src_in  = src_ff + 1'b1;
         end
         CMD_SHL_STEP: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[IDX_W-1:0];
            dst_in  = dst_ff + 1'b1;
            rd_en   = 1'b1;
            rd_addr = src_ff[IDX_W-1:0];
            src_in  = src_ff + 1'b1;
         end
         CMD_SHL_FIN: begin
            length_in = dst_ff;
         end
         CMD_TR_INIT: begin
            ptr_in    = trans_pos;
            cursor_in = trans_pos + 1'b1;
         end
         CMD_TR_RD_HI: begin
            rd_en = 1'b1;
         end
         CMD_TR_RD_LO: begin
            hold_in = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IDX_W-1:0];
         end
         CMD_TR_WR_HI: begin
            wr_en = 1'b1;
         end
         CMD_TR_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = ptr_dec[IDX_W-1:0];
            wr_data = hold_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         length_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      hold_ff <= hold_in;
      if (cmd.op == CMD_LOAD) begin
         key_ff    <= key_code;
         offset_ff <= move_offset;
         index_ff  <= read_index;
      end
      if (cmd.op == CMD_RESULT) begin
         res_accepted <= cmd.accepted;
         res_dropped  <= cmd.dropped;
         res_cursor   <= out_pos(cursor_ff);
         res_length   <= out_pos(length_ff);
         res_char     <= (cmd.with_read && index_in_line) ? rd_data_ff : '0;
      end
   end

   `CLE_ASSERT_ALWAYS(a_cursor_in_line, clock, reset, cursor_ff <= length_ff, "cursor past line end")
   `CLE_ASSERT_ALWAYS(a_length_bounded, clock, reset, length_ff <= POS_W'(LINE_LEN), "line overflow")
   `CLE_ASSERT_IMPLY(a_shl_order, clock, reset, cmd.op == CMD_SHL_STEP, dst_ff < src_ff, "shift overlap")

endmodule
`default_nettype wire

// ===== rtl/cle_ctrl.sv =====
// Line editor controller: decodes each request and sequences datapath commands.
// Depends on cle_pkg; drives cle_dpath through cmd_type and reads status_type.
`default_nettype none
module cle_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [cle_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [cle_pkg::KEY_W-1:0]       req_key,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire cle_pkg::status_type             status,
   output cle_pkg::cmd_type                     cmd
);
   import cle_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_HOME,
      S_END,
      S_KILL,
      S_MOVE,
      S_RDX,
      S_INS_INIT,
      S_SHR_ISSUE,
      S_SHR,
      S_PUT,
      S_BD,
      S_WD,
      S_SCAN,
      S_SHL_ISSUE,
      S_SHL,
      S_SHL_FIN,
      S_TR,
      S_TR_RH,
      S_TR_RL,
      S_TR_WH,
      S_TR_WL,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic acc_ff, acc_in;
   logic drop_ff, drop_in;
   logic rd_ff, rd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic printable;

   assign printable  = (req_key >= KEY_PRINT_LO) && (req_key <= KEY_PRINT_HI);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      drop_in       = drop_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      cmd.op        = CMD_NONE;
      cmd.accepted  = acc_ff;
      cmd.dropped   = drop_ff;
      cmd.with_read = rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op  = CMD_LOAD;
               acc_in  = 1'b0;
               drop_in = 1'b0;
               rd_in   = 1'b0;
               case (kind_type'(req_kind))
                  KIND_KEY: begin
                     acc_in = 1'b1;
                     if (printable) begin
                        if (status.full) begin
                           drop_in  = 1'b1;
                           state_in = S_RESP;
                        end else begin
                           state_in = S_INS_INIT;
                        end
                     end else begin
                        case (req_key)
                           KEY_HOME:      state_in = S_HOME;
                           KEY_END:       state_in = S_END;
                           KEY_KILL:      state_in = S_KILL;
                           KEY_TRANSPOSE: state_in = S_TR;
                           KEY_WORD_DEL:  state_in = S_WD;
                           KEY_DEL:       state_in = S_BD;
                           default: begin
                              acc_in   = 1'b0;
                              state_in = S_RESP;
                           end
                        endcase
                     end
                  end
                  KIND_MOVE: state_in = S_MOVE;
                  KIND_READ: begin
                     rd_in    = 1'b1;
                     state_in = S_RDX;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_HOME: begin
            cmd.op   = CMD_HOME;
            state_in = S_RESP;
         end
         S_END: begin
            cmd.op   = CMD_END;
            state_in = S_RESP;
         end
         S_KILL: begin
            cmd.op   = CMD_KILL;
            state_in = S_RESP;
         end
         S_MOVE: begin
            cmd.op   = CMD_MOVE;
            state_in = S_RESP;
         end
         S_RDX: begin
            cmd.op   = CMD_RD_IDX;
            state_in = S_RESP;
         end
         S_INS_INIT: begin
            cmd.op   = CMD_INS_INIT;
            state_in = S_SHR_ISSUE;
         end
         S_SHR_ISSUE: begin
            if (status.ptr_at_cursor) begin
               state_in = S_PUT;
            end else begin
               cmd.op   = CMD_SHR_ISSUE;
               state_in = S_SHR;
            end
         end
         S_SHR: begin
            cmd.op = CMD_SHR_STEP;
            if (status.ptr_next_at_cursor) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.op   = CMD_PUT;
            state_in = S_RESP;
         end
         S_BD: begin
            if (status.cursor_zero) begin
               state_in = S_RESP;
            end else begin
               cmd.op   = CMD_DEL_INIT;
               state_in = S_SHL_ISSUE;
            end
         end
         S_WD: begin
            if (status.cursor_zero) begin
               state_in = S_RESP;
            end else if (status.cursor_one) begin
               cmd.op   = CMD_DEL_INIT;
               state_in = S_SHL_ISSUE;
            end else begin
               cmd.op   = CMD_SCAN_INIT;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.space_hit) begin
               cmd.op   = CMD_SCAN_SPACE;
               state_in = S_SHL_ISSUE;
            end else if (status.ptr_zero) begin
               cmd.op   = CMD_SCAN_ZERO;
               state_in = S_SHL_ISSUE;
            end else begin
               cmd.op = CMD_SCAN_STEP;
            end
         end
         S_SHL_ISSUE: begin
            if (status.src_at_end) begin
               cmd.op   = CMD_SHL_FIN;
               state_in = S_RESP;
            end else begin
               cmd.op   = CMD_SHL_ISSUE;
               state_in = S_SHL;
            end
         end
         S_SHL: begin
            cmd.op = CMD_SHL_STEP;
            if (status.src_at_end) begin
               state_in = S_SHL_FIN;
            end
         end
         S_SHL_FIN: begin
            cmd.op   = CMD_SHL_FIN;
            state_in = S_RESP;
         end
         S_TR: begin
            if (status.short_line || status.cursor_zero) begin
               state_in = S_RESP;
            end else begin
               cmd.op   = CMD_TR_INIT;
               state_in = S_TR_RH;
            end
         end
         S_TR_RH: begin
            cmd.op   = CMD_TR_RD_HI;
            state_in = S_TR_RL;
         end
         S_TR_RL: begin
            cmd.op   = CMD_TR_RD_LO;
            state_in = S_TR_WH;
         end
         S_TR_WH: begin
            cmd.op   = CMD_TR_WR_HI;
            state_in = S_TR_WL;
         end
         S_TR_WL: begin
            cmd.op   = CMD_TR_WR_LO;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = CMD_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         rd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         drop_ff      <= drop_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/console_line_editor.sv =====
// Line editor top level over cle_pkg, cle_ctrl and cle_dpath; one transaction at a time.
// Unknown keys, kind 3 and a byte dropped on a full line go straight to the response; home,
// end, kill, move and read each issue one command; transpose reads and rewrites two bytes;
// insert shifts the tail right and delete shifts it left, the memory moving one byte a cycle;
// word delete first scans back for a space; a held result stalls the response.
// Reset clears cursor, length and both handshakes; line memory is not cleared.
`default_nettype none
module console_line_editor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // key_code [7:0], move_offset [17:8], read_index [25:18]
   input  wire logic [cle_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [1:0]
   input  wire logic [cle_pkg::KIND_W-1:0]         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // accepted [0], dropped_full [1], cursor_pos [10:2], line_length [19:11], read_char [27:20]
   output logic [cle_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import cle_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [KEY_W-1:0]           key_code;
   logic signed [OFFSET_W-1:0] move_offset;
   logic [RIDX_W-1:0]          read_index;
   logic                       res_accepted;
   logic                       res_dropped;
   logic [OUT_POS_W-1:0]       res_cursor;
   logic [OUT_POS_W-1:0]       res_length;
   logic [CHAR_W-1:0]          res_char;

   assign key_code    = req_tdata[KEY_W-1:0];
   assign move_offset = $signed(req_tdata[KEY_W+OFFSET_W-1:KEY_W]);
   assign read_index  = req_tdata[KEY_W+OFFSET_W+RIDX_W-1:KEY_W+OFFSET_W];

   cle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_key    (key_code),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cle_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .key_code     (key_code),
      .move_offset  (move_offset),
      .read_index   (read_index),
      .status       (status),
      .res_accepted (res_accepted),
      .res_dropped  (res_dropped),
      .res_cursor   (res_cursor),
      .res_length   (res_length),
      .res_char     (res_char)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, res_char, res_length, res_cursor,
                       res_dropped, res_accepted};

endmodule
`default_nettype wire
